// ----- sv/ebrg_pkg.sv -----
// ----------------------------------------------------------------------------
// ebrg_pkg
// Shared widths, register and field codes, control structs and clip helper
// for the ellipse band rectangle generator.
// ----------------------------------------------------------------------------
package ebrg_pkg;

  localparam int RAD_W      = 6;   // radius field width
  localparam int COORD_W    = 10;  // screen coordinate width
  localparam int POS_W      = 13;  // signed working width for edges
  localparam int DY_W       = 9;   // signed band row offset
  localparam int SQ_W       = 2 * RAD_W;
  localparam int RHS_W      = 4 * RAD_W;
  localparam int COLOR_W    = 16;
  localparam int SLOT_W     = 6;
  localparam int FIELD_W    = 11;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 1;

  // s_tuser bit positions
  localparam int USER_OPCODE   = 0;
  localparam int USER_NEW_LIST = 1;

  localparam logic OP_RECT    = 1'b0;
  localparam logic OP_ELLIPSE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [COORD_W-1:0] SCREEN_RESET = 10'd240;

  typedef struct packed {
    logic load;       // input transfer
    logic init;       // radius squares, first band offset
    logic band_diff;  // ry^2 - dy^2
    logic band_rhs;   // rx^2 * (ry^2 - dy^2), search reset
    logic srch_sq;    // candidate squared
    logic srch_cmp;   // compare, keep bit
    logic geom;       // band edges
    logic emit;       // load output register, step band
  } ebrg_cmd_t;

  typedef struct packed {
    logic is_rect;
    logic is_null;
    logic band_last;
    logic srch_done;
    logic out_free;
  } ebrg_status_t;

  function automatic logic [COORD_W-1:0] clip_coord(input logic signed [POS_W-1:0] v,
                                                    input logic [COORD_W-1:0] hi);
    logic signed [POS_W-1:0] hi_s;
    hi_s = signed'({{(POS_W-COORD_W){1'b0}}, hi});
    if (v < 0) begin
      return '0;
    end else if (v > hi_s) begin
      return hi;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

// ----- sv/ebrg_ctrl.sv -----
// ----------------------------------------------------------------------------
// ebrg_ctrl
// Sequencer: walks each command through setup, per-band half-width search
// (ellipses only) and output, one result at a time.
// ----------------------------------------------------------------------------
module ebrg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  ebrg_pkg::ebrg_status_t status,
  output ebrg_pkg::ebrg_cmd_t    cmd
);
  import ebrg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_RHS  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_GEOM = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = (status.is_rect || status.is_null) ? S_EMIT : S_DIFF;
      end
      S_DIFF: begin
        cmd.band_diff = 1'b1;
        state_next    = S_RHS;
      end
      S_RHS: begin
        cmd.band_rhs = 1'b1;
        state_next   = S_SQ;
      end
      S_SQ: begin
        cmd.srch_sq = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = status.srch_done ? S_GEOM : S_SQ;
      end
      S_GEOM: begin
        cmd.geom   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.is_rect || status.is_null || status.band_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_DIFF;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/ebrg_dp.sv -----
// ----------------------------------------------------------------------------
// ebrg_dp
// Datapath: config registers, command capture, bitwise band half-width
// search (square, then compare), clipping, slot counter and output register.
// ----------------------------------------------------------------------------
module ebrg_dp #(
  parameter int MAX_RECTS  = 64,
  parameter int BAND_ROWS  = 2,
  parameter int MAX_RADIUS = 63
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ebrg_pkg::ebrg_cmd_t                cmd,
  output ebrg_pkg::ebrg_status_t             status,
  input  logic [ebrg_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [ebrg_pkg::IN_USER_W-1:0]     s_tuser,
  input  logic                               cfg_wr,
  input  logic [ebrg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ebrg_pkg::COORD_W-1:0]       cfg_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ebrg_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [ebrg_pkg::OUT_USER_W-1:0]    m_tuser,
  output logic                               m_tlast
);
  import ebrg_pkg::*;

  localparam int CNT_W  = $clog2(MAX_RECTS + 1);
  localparam int BIT_W  = $clog2(RAD_W);
  localparam int PAD_W  = OUT_DATA_W - 4 * COORD_W - COLOR_W - SLOT_W;

  // config
  logic [COORD_W-1:0] screen_w;
  logic [COORD_W-1:0] screen_h;

  // captured command
  logic                      is_rect;
  logic                      is_null;
  logic signed [POS_W-1:0]   px;
  logic signed [POS_W-1:0]   py;
  logic [RAD_W-1:0]          rx;
  logic [RAD_W-1:0]          ry;
  logic [COLOR_W-1:0]        color;

  // search state
  logic [SQ_W-1:0]           rx2;
  logic [SQ_W-1:0]           ry2;
  logic signed [DY_W-1:0]    dy;
  logic [SQ_W-1:0]           diff;
  logic [RHS_W-1:0]          rhs;
  logic [SQ_W-1:0]           sq;
  logic [RAD_W-1:0]          hw;
  logic [BIT_W-1:0]          bit_idx;

  // current rectangle edges
  logic signed [POS_W-1:0]   x_lo;
  logic signed [POS_W-1:0]   x_hi;
  logic signed [POS_W-1:0]   y_lo;
  logic signed [POS_W-1:0]   y_hi;

  logic [CNT_W-1:0]          entry_count;

  // input field unpack
  logic signed [FIELD_W-1:0] in_px, in_py, in_w, in_h;
  logic [RAD_W-1:0]          in_rx, in_ry, rx_sat, ry_sat;
  logic [COLOR_W-1:0]        in_color;
  logic                      in_ellipse;

  assign in_px      = s_tdata[FIELD_W-1:0];
  assign in_py      = s_tdata[2*FIELD_W-1:FIELD_W];
  assign in_w       = s_tdata[3*FIELD_W-1:2*FIELD_W];
  assign in_h       = s_tdata[4*FIELD_W-1:3*FIELD_W];
  assign in_rx      = s_tdata[4*FIELD_W+RAD_W-1:4*FIELD_W];
  assign in_ry      = s_tdata[4*FIELD_W+2*RAD_W-1:4*FIELD_W+RAD_W];
  assign in_color   = s_tdata[4*FIELD_W+2*RAD_W+COLOR_W-1:4*FIELD_W+2*RAD_W];
  assign in_ellipse = (s_tuser[USER_OPCODE] == OP_ELLIPSE);

  assign rx_sat = (in_rx > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : in_rx;
  assign ry_sat = (in_ry > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : in_ry;

  // band arithmetic
  logic signed [DY_W-1:0]  ry_s;
  logic signed [DY_W-1:0]  dy_abs;
  logic [SQ_W-1:0]         dsq;
  logic [RAD_W-1:0]        cand;
  logic [RHS_W-1:0]        lhs;
  logic                    band_last;

  assign ry_s      = signed'(DY_W'(ry));
  assign dy_abs    = (dy < 0) ? -dy : dy;
  assign dsq       = dy_abs[RAD_W-1:0] * dy_abs[RAD_W-1:0];
  assign cand      = hw | (RAD_W'(1) << bit_idx);
  assign lhs       = RHS_W'(sq) * RHS_W'(ry2);
  assign band_last = (dy + DY_W'(BAND_ROWS)) > ry_s;

  // clip and store decision
  logic [COORD_W-1:0] x1, x2, y1, y2;
  logic               ok;
  logic               res_last;

  assign x1 = clip_coord(x_lo, screen_w);
  assign x2 = clip_coord(x_hi, screen_w);
  assign y1 = clip_coord(y_lo, screen_h);
  assign y2 = clip_coord(y_hi, screen_h);
  assign ok = !is_null && (x2 > x1) && (y2 > y1) && (entry_count < CNT_W'(MAX_RECTS));
  assign res_last = is_rect || is_null || band_last;

  assign status.is_rect   = is_rect;
  assign status.is_null   = is_null;
  assign status.band_last = band_last;
  assign status.srch_done = (bit_idx == '0);
  assign status.out_free  = !m_tvalid || m_tready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w    <= SCREEN_RESET;
      screen_h    <= SCREEN_RESET;
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  screen_w <= cfg_data;
          REG_SCREEN_HEIGHT: screen_h <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && s_tuser[USER_NEW_LIST]) begin
        entry_count <= '0;
      end else if (cmd.emit && ok) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_rect <= !in_ellipse;
      is_null <= in_ellipse && (rx_sat == '0 || ry_sat == '0);
      px      <= POS_W'(in_px);
      py      <= POS_W'(in_py);
      rx      <= rx_sat;
      ry      <= ry_sat;
      color   <= in_color;
      x_lo    <= POS_W'(in_px);
      y_lo    <= POS_W'(in_py);
      x_hi    <= POS_W'(in_px) + POS_W'(in_w);
      y_hi    <= POS_W'(in_py) + POS_W'(in_h);
    end
    if (cmd.init) begin
      rx2 <= rx * rx;
      ry2 <= ry * ry;
      dy  <= -ry_s;
    end
    if (cmd.band_diff) begin
      diff <= ry2 - dsq;
    end
    if (cmd.band_rhs) begin
      rhs     <= RHS_W'(rx2) * RHS_W'(diff);
      hw      <= '0;
      bit_idx <= BIT_W'(RAD_W - 1);
    end
    if (cmd.srch_sq) begin
      sq <= cand * cand;
    end
    if (cmd.srch_cmp) begin
      if (lhs <= rhs) begin
        hw <= cand;
      end
      if (bit_idx != '0) begin
        bit_idx <= bit_idx - BIT_W'(1);
      end
    end
    if (cmd.geom) begin
      x_lo <= px - POS_W'(hw);
      x_hi <= px + POS_W'(hw) + POS_W'(1);
      y_lo <= py + POS_W'(dy);
      y_hi <= band_last ? (py + POS_W'(ry_s) + POS_W'(1))
                        : (py + POS_W'(dy) + POS_W'(BAND_ROWS));
    end
    if (cmd.emit) begin
      dy      <= dy + DY_W'(BAND_ROWS);
      m_tuser <= ok;
      m_tlast <= res_last;
      if (ok) begin
        m_tdata <= {{PAD_W{1'b0}}, entry_count[SLOT_W-1:0], color,
                    y2 - y1, x2 - x1, y1, x1};
      end else begin
        m_tdata <= {{PAD_W{1'b0}}, {SLOT_W{1'b0}}, color, {(4*COORD_W){1'b0}}};
      end
    end
  end

endmodule

// ----- sv/ellipse_band_rect_generator.sv -----
// ----------------------------------------------------------------------------
// ellipse_band_rect_generator
// Display-list builder: clips rectangles, cuts filled ellipses into bands.
// ----------------------------------------------------------------------------
// Rectangle or null ellipse: one result, output after the init state.
// Ellipse: one result per band; emit waits for a free output register. Per band:
//   setup (diff, rhs), a 6-bit half-width search, square then compare per bit,
//   through one squarer and one compare multiplier, edge calc and output load.
// One command at a time; the next input is taken once the last result sits
// in the output register. Reset: screen 240x240, slot counter 0, idle.
module ellipse_band_rect_generator #(
  parameter int MAX_RECTS  = 64,
  parameter int BAND_ROWS  = 2,
  parameter int MAX_RADIUS = 63
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pos_x, pos_y, size_w, size_h, radius_x, radius_y, fill_color
  input  logic [ebrg_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode, new_list
  input  logic [ebrg_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ebrg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ebrg_pkg::COORD_W-1:0]     cfg_data,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // rect_x, rect_y, rect_w, rect_h, rect_color, slot, 2 zero bits
  output logic [ebrg_pkg::OUT_DATA_W-1:0]  m_tdata,
  // drawn
  output logic [ebrg_pkg::OUT_USER_W-1:0]  m_tuser,
  output logic                             m_tlast
);
  import ebrg_pkg::*;

  ebrg_cmd_t    cmd;
  ebrg_status_t status;

  assign cfg_ready = 1'b1;

  ebrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ebrg_dp #(
    .MAX_RECTS  (MAX_RECTS),
    .BAND_ROWS  (BAND_ROWS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // a stored rectangle is never degenerate
  a_drawn_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[29:20] != '0) && (m_tdata[39:30] != '0))
    else $error("drawn rectangle with zero size");

  // a result that is not stored carries only its color
  a_undrawn_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[39:0] == '0) && (m_tdata[61:56] == '0))
    else $error("undrawn result with nonzero geometry or slot");

  // output register only loaded when free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwritten before transfer");

  // an accepted command keeps the block busy, so input is not taken twice in a row
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

endmodule

// ----- dv/ellipse_band_rect_generator_test.sv -----
// ----------------------------------------------------------------------------
// ellipse_band_rect_generator_test
// Self-checking bench for the display-list builder. Drives rectangle and
// filled-ellipse commands over the input stream, predicts every clipped
// rectangle and band in order, and compares each output transfer field by
// field. Covers several screen clip settings, list overflow, null ellipses
// and random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module ellipse_band_rect_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ebrg_pkg::*;

  localparam int MAX_RECTS  = 64;
  localparam int BAND_ROWS  = 2;
  localparam int MAX_RADIUS = 63;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic               opcode;
    logic               new_list;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic signed [10:0] size_w;
    logic signed [10:0] size_h;
    logic [5:0]         radius_x;
    logic [5:0]         radius_y;
    logic [15:0]        color;
  } command_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [9:0]  w;
    logic [9:0]  h;
    logic [15:0] color;
    logic [5:0]  slot;
    logic        drawn;
    logic        last;
  } rect_t;

  // Predicts the rectangle stream and holds rectangles not yet seen.
  class display_list_model;
    rect_t      pending_rects[$];
    logic [6:0] entry_count;
    logic [9:0] screen_w;
    logic [9:0] screen_h;
    int         errors;
    int         commands;
    int         checked;
    int         stored;
    int         full_drops;

    function new();
      entry_count = '0;
      screen_w = SCREEN_RESET;
      screen_h = SCREEN_RESET;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
      if (idx == REG_SCREEN_WIDTH) begin
        screen_w = value;
      end else begin
        screen_h = value;
      end
    endfunction

    function int clip_to(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function void push_rect(int x, int y, int w, int h, logic [15:0] color, bit last);
      int    x1, y1, x2, y2;
      bit    nonempty;
      rect_t r;
      x1 = clip_to(x, screen_w);
      y1 = clip_to(y, screen_h);
      x2 = clip_to(x + w, screen_w);
      y2 = clip_to(y + h, screen_h);
      nonempty = (x2 > x1) && (y2 > y1);
      r = '0;
      r.color = color;
      r.last = last;
      if (nonempty && entry_count < MAX_RECTS) begin
        r.x = x1[9:0];
        r.y = y1[9:0];
        r.w = 10'(x2 - x1);
        r.h = 10'(y2 - y1);
        r.slot = entry_count[5:0];
        r.drawn = 1'b1;
        entry_count++;
        stored++;
      end else if (nonempty) begin
        full_drops++;
      end
      pending_rects.push_back(r);
    endfunction

    // largest x with x^2*ry^2 + dy^2*rx^2 <= rx^2*ry^2
    function int band_half_width(int rx, int ry, int dy);
      longint rx2, ry2, bound, dterm;
      rx2 = longint'(rx) * rx;
      ry2 = longint'(ry) * ry;
      bound = rx2 * ry2;
      dterm = longint'(dy) * dy * rx2;
      for (int x = rx; x >= 0; x--) begin
        if (longint'(x) * x * ry2 + dterm <= bound) return x;
      end
      return 0;
    endfunction

    function void take_command(command_t c);
      int    rx, ry, bh, hw;
      rect_t r;
      commands++;
      if (c.new_list) entry_count = '0;
      if (entry_count > MAX_RECTS) entry_count = 7'(MAX_RECTS);
      if (c.opcode == OP_RECT) begin
        push_rect(c.pos_x, c.pos_y, c.size_w, c.size_h, c.color, 1'b1);
        return;
      end
      rx = (c.radius_x > MAX_RADIUS) ? MAX_RADIUS : c.radius_x;
      ry = (c.radius_y > MAX_RADIUS) ? MAX_RADIUS : c.radius_y;
      if (rx == 0 || ry == 0) begin
        r = '0;
        r.color = c.color;
        r.last = 1'b1;
        pending_rects.push_back(r);
        return;
      end
      for (int dy = -ry; dy <= ry; dy += BAND_ROWS) begin
        bh = BAND_ROWS;
        if (dy + bh > ry + 1) bh = ry + 1 - dy;   // trim last band to row ry
        hw = band_half_width(rx, ry, dy);
        push_rect(int'(c.pos_x) - hw, int'(c.pos_y) + dy, 2 * hw + 1, bh, c.color,
                  dy + BAND_ROWS > ry);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_rect(rect_t got);
      rect_t want;
      checked++;
      if (pending_rects.size() == 0) begin
        errors++;
        $display("%0t: unexpected rectangle, expected none, got %h", $time, got);
        return;
      end
      want = pending_rects.pop_front();
      compare_field("rect_x", want.x, got.x);
      compare_field("rect_y", want.y, got.y);
      compare_field("rect_w", want.w, got.w);
      compare_field("rect_h", want.h, got.h);
      compare_field("rect_color", want.color, got.color);
      compare_field("slot", want.slot, got.slot);
      compare_field("drawn", want.drawn, got.drawn);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata;
  logic [IN_USER_W-1:0]    s_tuser;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [COORD_W-1:0]      cfg_data;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [OUT_USER_W-1:0]   m_tuser;
  logic                    m_tlast;

  display_list_model model;
  bit                source_steady;
  bit                sink_steady;
  int                hold_request;

  ellipse_band_rect_generator #(
    .MAX_RECTS(MAX_RECTS),
    .BAND_ROWS(BAND_ROWS),
    .MAX_RADIUS(MAX_RADIUS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #2 clk = ~clk;

  initial begin
    #10ms;
    $display("timeout with %0d rectangles outstanding", model.pending_rects.size());
    $display("[ellipse_band_rect_generator] ERROR");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic command_t make_cmd(logic op, logic nl, int px, int py, int w, int h,
                                        int rx, int ry, logic [15:0] color);
    command_t c;
    c.opcode = op;
    c.new_list = nl;
    c.pos_x = 11'(px);
    c.pos_y = 11'(py);
    c.size_w = 11'(w);
    c.size_h = 11'(h);
    c.radius_x = 6'(rx);
    c.radius_y = 6'(ry);
    c.color = color;
    return c;
  endfunction

  function automatic command_t rand_command();
    command_t c;
    int       kind;
    kind = $urandom_range(0, 99);
    c.opcode = (kind < 35) ? OP_RECT : OP_ELLIPSE;
    c.new_list = ($urandom_range(0, 9) == 0);
    c.color = 16'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      c.pos_x = 11'($urandom);
      c.pos_y = 11'($urandom);
    end else begin
      c.pos_x = 11'(int'($urandom_range(0, 330)) - 30);
      c.pos_y = 11'(int'($urandom_range(0, 330)) - 30);
    end
    if ($urandom_range(0, 4) == 0) begin
      c.size_w = 11'($urandom);
      c.size_h = 11'($urandom);
    end else begin
      c.size_w = 11'(int'($urandom_range(0, 220)) - 20);
      c.size_h = 11'(int'($urandom_range(0, 220)) - 20);
    end
    c.radius_x = 6'($urandom_range(1, 63));
    c.radius_y = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(1, 63))
                                             : 6'($urandom_range(1, 12));
    if (kind >= 90) begin
      // null ellipse: one radius zero
      if ($urandom_range(0, 1)) c.radius_x = '0;
      else c.radius_y = '0;
    end
    return c;
  endfunction

  task automatic send_command(command_t c, int gap);
    logic [IN_USER_W-1:0] user;
    user = '0;
    user[USER_OPCODE] = c.opcode;
    user[USER_NEW_LIST] = c.new_list;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {c.color, c.radius_y, c.radius_x, c.size_h, c.size_w, c.pos_y, c.pos_x};
    s_tuser <= user;
    do @(posedge clk); while (!s_tready);
    model.take_command(c);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    model.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (model.pending_rects.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int    stall_left;
    rect_t got;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (hold_request > 0) begin
        m_tready <= 1'b0;
        stall_left = hold_request - 1;
        hold_request = 0;
      end else if (sink_steady) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          stall_left--;
        end
      end
      @(posedge clk);
      if (m_tvalid && m_tready && !rst) begin
        got.x = m_tdata[9:0];
        got.y = m_tdata[19:10];
        got.w = m_tdata[29:20];
        got.h = m_tdata[39:30];
        got.color = m_tdata[55:40];
        got.slot = m_tdata[61:56];
        got.drawn = m_tuser[0];
        got.last = m_tlast;
        model.check_rect(got);
      end
    end
  end

  initial begin
    command_t         directed[$];
    logic [COORD_W-1:0] widths[6];
    logic [COORD_W-1:0] heights[6];
    model = new();
    source_steady = 1'b0;
    sink_steady = 1'b0;
    hold_request = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    widths = '{10'd100, 10'd1023, 10'd1, 10'd0, 10'd240, 10'd511};
    heights = '{10'd60, 10'd1023, 10'd1, 10'd240, 10'd0, 10'd1023};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed commands on the reset screen of 240x240
    directed.push_back(make_cmd(OP_RECT, 1, 10, 20, 30, 40, 0, 0, 16'h0000));
    directed.push_back(make_cmd(OP_RECT, 0, -1024, -1024, 1023, 1023, 63, 63, 16'hFFFF));
    directed.push_back(make_cmd(OP_RECT, 0, -5, -5, 20, 20, 0, 0, 16'h1234));
    directed.push_back(make_cmd(OP_RECT, 0, 1023, 1023, 5, 5, 0, 0, 16'h8001));
    directed.push_back(make_cmd(OP_RECT, 0, 200, 200, 1023, 1023, 0, 0, 16'hF800));
    directed.push_back(make_cmd(OP_RECT, 0, 50, 50, -20, -1024, 0, 0, 16'h07E0));
    directed.push_back(make_cmd(OP_RECT, 0, 0, 0, 0, 0, 0, 0, 16'h001F));
    directed.push_back(make_cmd(OP_RECT, 0, 0, 0, 1023, 1023, 0, 0, 16'hAAAA));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 100, 100, 0, 0, 0, 5, 16'h5555));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 100, 100, 0, 0, 5, 0, 16'h0F0F));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 100, 100, 0, 0, 0, 0, 16'hF0F0));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 120, 120, 0, 0, 1, 1, 16'h00FF));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 60, 60, 0, 0, 7, 4, 16'hFF00));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 60, 60, 0, 0, 5, 3, 16'h3C3C));
    // fills the list part way through its bands
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 120, 120, 0, 0, 63, 63, 16'hC3C3));
    directed.push_back(make_cmd(OP_RECT, 0, 10, 10, 10, 10, 0, 0, 16'h7E7E));
    directed.push_back(make_cmd(OP_ELLIPSE, 1, 120, 120, 0, 0, 63, 1, 16'h8181));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, -1024, 1023, 1023, -1024, 10, 10, 16'h1111));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 0, 0, 0, 0, 20, 7, 16'h2222));
    directed.push_back(make_cmd(OP_ELLIPSE, 0, 1023, -1024, 0, 0, 63, 63, 16'h4444));
    directed.push_back(make_cmd(OP_ELLIPSE, 1, 239, 239, 0, 0, 2, 2, 16'hFFFF));
    foreach (directed[i]) send_command(directed[i], pick_gap());
    stop_sending();
    wait_drained();

    // random commands under several clip settings
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SCREEN_WIDTH, widths[p]);
      write_reg(REG_SCREEN_HEIGHT, heights[p]);
      source_steady = (p == 3);
      sink_steady = (p == 3);
      if (p == 1) hold_request = 400;   // output backs up, input stalls
      repeat (23) send_command(rand_command(), source_steady ? 0 : pick_gap());
      stop_sending();
      wait_drained();
    end

    $display("ran %0d commands, checked %0d rectangles: %0d stored, %0d refused on full list",
             model.commands, model.checked, model.stored, model.full_drops);
    $display("clip limits from 0 to 1023, null ellipses, list overflow, long output hold-off");
    if (model.errors == 0 && model.pending_rects.size() == 0) begin
      $display("[ellipse_band_rect_generator] OK");
    end else begin
      $display("[ellipse_band_rect_generator] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ebrg_pkg.sv
sv/ebrg_ctrl.sv
sv/ebrg_dp.sv
sv/ellipse_band_rect_generator.sv
dv/ellipse_band_rect_generator_test.sv
